// File: sv/vcg_pkg.sv
// vcg_pkg: shared constants, widths and reciprocal tables for the vhd chs geometry unit
// no dependencies; used by vcg_track_div and vhd_chs_geometry_unit

package vcg_pkg;

    // field widths
    localparam int SIZE_W   = 64;
    localparam int CYL_W    = 16;
    localparam int HEADS_W  = 5;
    localparam int SPT_W    = 6;
    localparam int PACK_W   = 32;

    // sector count after clamping fits in 28 bits
    localparam int SECT_SHIFT = 9;
    localparam int SECT_FULL_W = SIZE_W - SECT_SHIFT;
    localparam int SECT_W   = 28;
    localparam logic [SECT_FULL_W-1:0] MAX_SECTORS = 55'd65535 * 55'd16 * 55'd255;

    // track counts for any sectors per track fit in 24 bits
    localparam int TRK_W    = 24;

    // ceil division by a constant: quotient = (num * recip) >> RECIP_SHIFT, exact for num < 2^28
    localparam int RECIP_SHIFT = 34;
    localparam int RECIP_W  = 30;
    localparam int PROD_W   = SECT_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_17 = RECIP_W'(((64'd1 << 34) + 64'd16) / 64'd17);
    localparam logic [RECIP_W-1:0] RECIP_31 = RECIP_W'(((64'd1 << 34) + 64'd30) / 64'd31);
    localparam logic [RECIP_W-1:0] RECIP_63 = RECIP_W'(((64'd1 << 34) + 64'd62) / 64'd63);

    // sectors per track choices
    localparam logic [SPT_W-1:0] SPT_17 = 6'd17;
    localparam logic [SPT_W-1:0] SPT_31 = 6'd31;
    localparam logic [SPT_W-1:0] SPT_63 = 6'd63;

    // head limits and track rounding
    localparam int HEAD_SHIFT = 10;
    localparam int HCALC_W  = TRK_W + 1 - HEAD_SHIFT;
    localparam logic [HEADS_W-1:0] HEADS_MIN = 5'd4;
    localparam logic [HEADS_W-1:0] HEADS_MAX = 5'd16;
    localparam logic [TRK_W:0] TRK_ROUND = 25'd1023;
    localparam logic [TRK_W-1:0] TRK_LIMIT_16 = 24'd16384;

    // small divide of tracks by heads 4..16: (trk * recip) >> HDIV_SHIFT, exact for trk < 2^14
    localparam int HDIV_NUM_W = 14;
    localparam int HDIV_SHIFT = 20;
    localparam int HDIV_RECIP_W = 19;
    localparam int HDIV_PROD_W = HDIV_NUM_W + HDIV_RECIP_W;
    localparam int HDIV_Q_W = HDIV_PROD_W - HDIV_SHIFT;

    localparam logic [CYL_W-1:0] CYL_MAX = 16'hFFFF;

    // reciprocal of the head count, rounded up
    function automatic logic [HDIV_RECIP_W-1:0] head_recip(input logic [HEADS_W-1:0] h);
        logic [HDIV_RECIP_W-1:0] r;
        unique case (h)
            5'd4:    r = 19'(((32'd1 << 20) + 32'd3)  / 32'd4);
            5'd5:    r = 19'(((32'd1 << 20) + 32'd4)  / 32'd5);
            5'd6:    r = 19'(((32'd1 << 20) + 32'd5)  / 32'd6);
            5'd7:    r = 19'(((32'd1 << 20) + 32'd6)  / 32'd7);
            5'd8:    r = 19'(((32'd1 << 20) + 32'd7)  / 32'd8);
            5'd9:    r = 19'(((32'd1 << 20) + 32'd8)  / 32'd9);
            5'd10:   r = 19'(((32'd1 << 20) + 32'd9)  / 32'd10);
            5'd11:   r = 19'(((32'd1 << 20) + 32'd10) / 32'd11);
            5'd12:   r = 19'(((32'd1 << 20) + 32'd11) / 32'd12);
            5'd13:   r = 19'(((32'd1 << 20) + 32'd12) / 32'd13);
            5'd14:   r = 19'(((32'd1 << 20) + 32'd13) / 32'd14);
            5'd15:   r = 19'(((32'd1 << 20) + 32'd14) / 32'd15);
            5'd16:   r = 19'(((32'd1 << 20) + 32'd15) / 32'd16);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: sv/vhd_chs_geometry_unit.sv
// vhd_chs_geometry_unit: maps a disk size in bytes to a cylinder/head/sector geometry
// depends on vcg_pkg and vcg_track_div
// accepts one item per cycle
// busy is always low; four register stages (clamp, track divide, head select, cylinder divide)
// reset clears the stage valid bits only; the receiver cannot stall the result

module vhd_chs_geometry_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [vcg_pkg::SIZE_W-1:0]       i_size_bytes,
    output logic                             o_strobe,
    output logic [vcg_pkg::CYL_W-1:0]        o_cylinders,
    output logic [vcg_pkg::HEADS_W-1:0]      o_heads,
    output logic [vcg_pkg::SPT_W-1:0]        o_sectors_per_track,
    output logic [vcg_pkg::PACK_W-1:0]       o_packed_geometry
);

    // stage valid bits
    logic r_v1, r_v2, r_v3, r_v4;

    // stage 1: sector count, clamped, with ceiling offsets
    logic [vcg_pkg::SECT_FULL_W-1:0] sect_full;
    logic [vcg_pkg::SECT_W-1:0]      sect;
    logic [vcg_pkg::SECT_W-1:0]      r_n17, r_n31, r_n63;

    assign sect_full = i_size_bytes[vcg_pkg::SIZE_W-1:vcg_pkg::SECT_SHIFT];
    assign sect = (sect_full > vcg_pkg::MAX_SECTORS) ?
                  vcg_pkg::SECT_W'(vcg_pkg::MAX_SECTORS) : sect_full[vcg_pkg::SECT_W-1:0];

    always_ff @(posedge i_clk) begin
        r_n17 <= sect + vcg_pkg::SECT_W'(16);
        r_n31 <= sect + vcg_pkg::SECT_W'(30);
        r_n63 <= sect + vcg_pkg::SECT_W'(62);
    end

    // stage 2: track counts for all three sectors-per-track choices
    logic [vcg_pkg::TRK_W-1:0] t17, t31, t63;

    vcg_track_div u_div17 (.i_clk(i_clk), .i_num(r_n17), .i_recip(vcg_pkg::RECIP_17),
                           .o_quot(t17));
    vcg_track_div u_div31 (.i_clk(i_clk), .i_num(r_n31), .i_recip(vcg_pkg::RECIP_31),
                           .o_quot(t31));
    vcg_track_div u_div63 (.i_clk(i_clk), .i_num(r_n63), .i_recip(vcg_pkg::RECIP_63),
                           .o_quot(t63));

    // stage 3: head count and geometry choice
    logic [vcg_pkg::TRK_W:0]         t17_rnd;
    logic [vcg_pkg::HCALC_W-1:0]     h17_raw;
    logic [vcg_pkg::HCALC_W-1:0]     h17;
    logic                            no_fit17;
    logic                            no_fit31;
    logic [vcg_pkg::TRK_W-1:0]       n_trk;
    logic [vcg_pkg::HEADS_W-1:0]     n_heads;
    logic [vcg_pkg::SPT_W-1:0]       n_spt;
    logic [vcg_pkg::TRK_W-1:0]       r_trk;
    logic [vcg_pkg::HEADS_W-1:0]     r_heads;
    logic [vcg_pkg::SPT_W-1:0]       r_spt;

    assign t17_rnd = {1'b0, t17} + vcg_pkg::TRK_ROUND;
    assign h17_raw = t17_rnd[vcg_pkg::TRK_W:vcg_pkg::HEAD_SHIFT];
    assign h17 = (h17_raw < vcg_pkg::HCALC_W'(vcg_pkg::HEADS_MIN)) ?
                 vcg_pkg::HCALC_W'(vcg_pkg::HEADS_MIN) : h17_raw;
    assign no_fit17 = ({1'b0, t17} >= {h17, {vcg_pkg::HEAD_SHIFT{1'b0}}}) ||
                      (h17 > vcg_pkg::HCALC_W'(vcg_pkg::HEADS_MAX));
    assign no_fit31 = (t31 >= vcg_pkg::TRK_LIMIT_16);

    always_comb begin
        priority if (!no_fit17) begin
            n_trk   = t17;
            n_heads = h17[vcg_pkg::HEADS_W-1:0];
            n_spt   = vcg_pkg::SPT_17;
        end else if (!no_fit31) begin
            n_trk   = t31;
            n_heads = vcg_pkg::HEADS_MAX;
            n_spt   = vcg_pkg::SPT_31;
        end else begin
            n_trk   = t63;
            n_heads = vcg_pkg::HEADS_MAX;
            n_spt   = vcg_pkg::SPT_63;
        end
    end

    always_ff @(posedge i_clk) begin
        r_trk   <= n_trk;
        r_heads <= n_heads;
        r_spt   <= n_spt;
    end

    // stage 4: cylinders = tracks / heads, saturated
    logic [vcg_pkg::HDIV_PROD_W-1:0]   hprod;
    logic [vcg_pkg::HDIV_Q_W-1:0]      hquot;
    logic [vcg_pkg::TRK_W-5:0]         q16;
    logic [vcg_pkg::CYL_W-1:0]         n_cyl;
    logic [vcg_pkg::CYL_W-1:0]         r_cyl;
    logic [vcg_pkg::HEADS_W-1:0]       r_heads_o;
    logic [vcg_pkg::SPT_W-1:0]         r_spt_o;

    assign hprod = vcg_pkg::HDIV_PROD_W'(r_trk[vcg_pkg::HDIV_NUM_W-1:0]) *
                   vcg_pkg::HDIV_PROD_W'(vcg_pkg::head_recip(r_heads));
    assign hquot = hprod[vcg_pkg::HDIV_PROD_W-1:vcg_pkg::HDIV_SHIFT];
    assign q16   = r_trk[vcg_pkg::TRK_W-1:4];

    always_comb begin
        if (r_heads == vcg_pkg::HEADS_MAX) begin
            n_cyl = (q16 > {4'h0, vcg_pkg::CYL_MAX}) ?
                    vcg_pkg::CYL_MAX : q16[vcg_pkg::CYL_W-1:0];
        end else begin
            n_cyl = vcg_pkg::CYL_W'(hquot);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cyl     <= n_cyl;
        r_heads_o <= r_heads;
        r_spt_o   <= r_spt;
    end

    // valid bits follow the items down the pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // outputs
    assign busy                = 1'b0;
    assign o_strobe            = r_v4;
    assign o_cylinders         = r_cyl;
    assign o_heads             = r_heads_o;
    assign o_sectors_per_track = r_spt_o;
    assign o_packed_geometry   = {r_cyl, 3'b000, r_heads_o, 2'b00, r_spt_o};

endmodule

// File: sv/vcg_track_div.sv
// vcg_track_div: one pipeline stage dividing a sector count by a constant via reciprocal
// depends on vcg_pkg for widths and the reciprocal shift

module vcg_track_div (
    input  logic                            i_clk,
    input  logic [vcg_pkg::SECT_W-1:0]      i_num,
    input  logic [vcg_pkg::RECIP_W-1:0]     i_recip,
    output logic [vcg_pkg::TRK_W-1:0]       o_quot
);

    logic [vcg_pkg::PROD_W-1:0] n_prod;
    logic [vcg_pkg::TRK_W-1:0]  r_quot;

    // multiply by the reciprocal, keep the integer part
    assign n_prod = vcg_pkg::PROD_W'(i_num) * vcg_pkg::PROD_W'(i_recip);

    always_ff @(posedge i_clk) begin
        r_quot <= n_prod[vcg_pkg::RECIP_SHIFT +: vcg_pkg::TRK_W];
    end

    assign o_quot = r_quot;

endmodule
